### hw/rtl/crbw_pkg.sv
package crbw_pkg;

  // fixed field widths
  localparam int PAT_W   = 24;
  localparam int TGT_W   = 2;
  localparam int REG_W   = 6;
  localparam int LEN_W   = 5;
  localparam int IDX_W   = 5;

  // defaults for the top-level parameters
  localparam int NUM_OUTPUTS_DEF = 24;
  localparam int NUM_TARGETS_DEF = 4;

  // first register of the output bank
  localparam logic [REG_W-1:0] REG_BASE = 6'h0F;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified item waiting for the run scanner
  typedef struct packed {
    logic [TGT_W-1:0] tgt;
    logic [PAT_W-1:0] diff;
    logic [PAT_W-1:0] newp;
  } crbw_entry_t;

  // mask of the n lowest bits
  function automatic logic [PAT_W-1:0] low_mask(input logic [LEN_W:0] n);
    logic [PAT_W-1:0] m;
    m = '0;
    for (int i = 0; i < PAT_W; i++) begin
      m[i] = ((LEN_W+1)'(i) < n);
    end
    return m;
  endfunction

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] first_one(input logic [PAT_W:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = PAT_W; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hw/rtl/crbw_front.sv
module crbw_front #(
  parameter int NUM_OUTPUTS = crbw_pkg::NUM_OUTPUTS_DEF,
  parameter int NUM_TARGETS = crbw_pkg::NUM_TARGETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [crbw_pkg::TGT_W-1:0] in_target,
  input  logic [crbw_pkg::PAT_W-1:0] in_pattern,
  output logic                       push,
  output crbw_pkg::crbw_entry_t      push_entry,
  input  logic                       queue_full
);
  import crbw_pkg::*;

  localparam int SEL_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

  logic [PAT_W-1:0] last_pat_r [NUM_TARGETS];
  logic [PAT_W-1:0] out_mask;
  logic [PAT_W-1:0] new_pat;
  logic [PAT_W-1:0] old_pat;
  logic [PAT_W-1:0] diff;
  logic [SEL_W-1:0] sel;
  logic             tgt_ok;
  logic             accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  // classify: target in range, which outputs changed
  assign out_mask = low_mask((LEN_W+1)'(NUM_OUTPUTS));
  assign new_pat  = in_pattern & out_mask;
  assign tgt_ok   = ({1'b0, in_target} < (TGT_W+1)'(NUM_TARGETS));
  assign sel      = SEL_W'(in_target);
  assign old_pat  = tgt_ok ? last_pat_r[sel] : '0;
  assign diff     = (new_pat ^ old_pat) & out_mask;

  // only items with at least one changed output go to the back end
  assign push            = accept && tgt_ok && (diff != '0);
  assign push_entry.tgt  = in_target;
  assign push_entry.diff = diff;
  assign push_entry.newp = new_pat;

  // per-target pattern record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TARGETS; t++) begin
        last_pat_r[t] <= '0;
      end
    end else if (accept && tgt_ok) begin
      last_pat_r[sel] <= new_pat;
    end
  end

endmodule

### hw/rtl/crbw_queue.sv
module crbw_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  crbw_pkg::crbw_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output crbw_pkg::crbw_entry_t pop_entry
);
  import crbw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  crbw_entry_t      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### hw/rtl/crbw_back.sv
module crbw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       not_empty,
  input  crbw_pkg::crbw_entry_t      pop_entry,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [crbw_pkg::TGT_W-1:0] out_dest,
  output logic [crbw_pkg::REG_W-1:0] out_start_register,
  output logic [crbw_pkg::LEN_W-1:0] out_run_length,
  output logic [crbw_pkg::PAT_W-1:0] out_run_bits,
  output logic                       out_last
);
  import crbw_pkg::*;

  logic             busy_r, busy_nxt;
  logic [PAT_W-1:0] rem_r, rem_nxt;
  logic [PAT_W-1:0] newp_r, newp_nxt;
  logic [TGT_W-1:0] tgt_r, tgt_nxt;

  logic             out_valid_r;
  logic [TGT_W-1:0] dest_r;
  logic [REG_W-1:0] start_reg_r;
  logic [LEN_W-1:0] len_r;
  logic [PAT_W-1:0] bits_r;
  logic             last_r;

  logic [IDX_W-1:0] run_start;
  logic [PAT_W-1:0] shifted;
  logic [IDX_W-1:0] run_len;
  logic [PAT_W-1:0] len_mask;
  logic [PAT_W-1:0] run_mask;
  logic [PAT_W-1:0] rem_left;
  logic             out_free;
  logic             emit;
  logic             final_run;

  // lowest run of changed outputs in what is left
  assign run_start = first_one({1'b0, rem_r});
  assign shifted   = rem_r >> run_start;
  assign run_len   = first_one({1'b1, ~shifted});
  assign len_mask  = low_mask({1'b0, run_len});
  assign run_mask  = len_mask << run_start;
  assign rem_left  = rem_r & ~run_mask;

  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = busy_r && out_free;
  assign final_run = (rem_left == '0);
  assign pop       = !busy_r || (emit && final_run);

  // scanner state: take a new item when idle or on its predecessor's last run
  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    newp_nxt = newp_r;
    tgt_nxt  = tgt_r;
    if (emit) begin
      rem_nxt = rem_left;
      if (final_run) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop && not_empty) begin
      busy_nxt = 1'b1;
      rem_nxt  = pop_entry.diff;
      newp_nxt = pop_entry.newp;
      tgt_nxt  = pop_entry.tgt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    newp_r <= newp_nxt;
    tgt_r  <= tgt_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dest_r      <= tgt_r;
      start_reg_r <= REG_BASE + REG_W'(run_start);
      len_r       <= LEN_W'(run_len);
      bits_r      <= (newp_r >> run_start) & len_mask;
      last_r      <= final_run;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dest           = dest_r;
  assign out_start_register = start_reg_r;
  assign out_run_length     = len_r;
  assign out_run_bits       = bits_r;
  assign out_last           = last_r;

endmodule

### hw/rtl/changed_output_run_burst_writer_top.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_target, in_pattern
// out_     output     out_valid/out_stall out_dest, out_start_register,
//                                        out_run_length, out_run_bits, out_last
//
// An item is classified and its target's record updated in the cycle it is
// accepted; items with changes wait in a two-entry queue. The run scanner
// emits one burst per cycle unless out_stall holds it; with 24 outputs an item
// has 1..12 runs. Reset (synchronous, rst_n low) clears all target records,
// the queue and the output register. in_stall rises only while the queue is
// full; out_stall holds the output register and, through it, the scanner.
module changed_output_run_burst_writer_top #(
  parameter int NUM_OUTPUTS = crbw_pkg::NUM_OUTPUTS_DEF,
  parameter int NUM_TARGETS = crbw_pkg::NUM_TARGETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [crbw_pkg::TGT_W-1:0] in_target,
  input  logic [crbw_pkg::PAT_W-1:0] in_pattern,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [crbw_pkg::TGT_W-1:0] out_dest,
  output logic [crbw_pkg::REG_W-1:0] out_start_register,
  output logic [crbw_pkg::LEN_W-1:0] out_run_length,
  output logic [crbw_pkg::PAT_W-1:0] out_run_bits,
  output logic                       out_last
);
  import crbw_pkg::*;

  crbw_entry_t push_entry;
  crbw_entry_t pop_entry;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        not_empty;

  crbw_front #(
    .NUM_OUTPUTS(NUM_OUTPUTS),
    .NUM_TARGETS(NUM_TARGETS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_target  (in_target),
    .in_pattern (in_pattern),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  crbw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .pop_entry  (pop_entry)
  );

  crbw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .not_empty          (not_empty),
    .pop_entry          (pop_entry),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_dest           (out_dest),
    .out_start_register (out_start_register),
    .out_run_length     (out_run_length),
    .out_run_bits       (out_run_bits),
    .out_last           (out_last)
  );

endmodule
